### sv/mtvb_pkg.sv
// Package: shared constants, types and helpers for the morph target vertex blend.
`timescale 1ns / 1ps
package mtvb_pkg;

    localparam int VERTEX_SLOTS_DEF = 4096;
    localparam int MAX_TARGETS_DEF  = 16;

    localparam int SLOT_W   = 12;
    localparam int TARGET_W = 4;
    localparam int WEIGHT_W = 16;
    localparam int POS_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int TOTAL_W  = 21;
    localparam int T_W      = 17;   // blend factor, below 2.0 with 16 fraction bits

    localparam logic signed [TOTAL_W-1:0] ONE_Q14 = TOTAL_W'(16384);

    typedef enum logic [1:0] {
        FUNC_WEIGHT = 2'd0,
        FUNC_BASE   = 2'd1,
        FUNC_BLEND  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic {
        REG_BLEND_MODE     = 1'b0,
        REG_FRAME_FRACTION = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MUL,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Saturate a 50-bit sum to the signed 32-bit range.
    function automatic logic signed [POS_W-1:0] sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        begin
            hi = 50'sd2147483647;
            lo = -50'sd2147483648;
            if (v > hi)
                sat32 = 32'sh7fffffff;
            else if (v < lo)
                sat32 = 32'sh80000000;
            else
                sat32 = v[POS_W-1:0];
        end
    endfunction

endpackage

### sv/mtvb_div.sv
// Restoring divider for the normalised blend factor: floor(w * 2^16 / total).
`timescale 1ns / 1ps
module mtvb_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mtvb_pkg::WEIGHT_W-2:0]  dividend_w,  // non-negative weight
    input  logic [mtvb_pkg::TOTAL_W-1:0]   divisor,     // positive total
    output logic                           done,
    output logic [mtvb_pkg::T_W-1:0]       quotient
);
    import mtvb_pkg::*;

    localparam int NUM_W = WEIGHT_W - 1 + 16;   // 31-bit numerator
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   num_reg, num_next;
    logic [TOTAL_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [TOTAL_W:0]   trial;

    // One quotient bit per cycle
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[TOTAL_W-1:0], num_reg[NUM_W-1]};
        if (start)
        begin
            num_next  = {dividend_w, 16'd0};
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[T_W-1:0];

endmodule

### sv/mtvb_store.sv
// Position store: one synchronous memory of x, y, z per vertex slot.
`timescale 1ns / 1ps
module mtvb_store #(
    parameter int VERTEX_SLOTS = mtvb_pkg::VERTEX_SLOTS_DEF,
    parameter int ADDR_W       = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [3*mtvb_pkg::POS_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [3*mtvb_pkg::POS_W-1:0]  wr_data
);
    import mtvb_pkg::*;

    logic [3*POS_W-1:0] mem [VERTEX_SLOTS];
    logic [3*POS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/morph_target_vertex_blend_core.sv
// Top level: morph target vertex blend with weight table and position store.
`timescale 1ns / 1ps
// One item at a time. Weight writes and base loads complete when accepted. A
// blend steps through store read, multiply, write-back and output; outside
// frame mode, when the weight total exceeds 1.0 and the weight is
// non-negative, the bit-serial divider runs first. The result then
// waits in an output register until it is transferred. The single read/write
// port pair of the position store sets the read-modify-write sequence.
module morph_target_vertex_blend_core #(
    parameter int VERTEX_SLOTS = mtvb_pkg::VERTEX_SLOTS_DEF,
    parameter int MAX_TARGETS  = mtvb_pkg::MAX_TARGETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [mtvb_pkg::FRAC_W-1:0]         cfg_data,
    // input items
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic [mtvb_pkg::SLOT_W-1:0]         slot,
    input  logic [mtvb_pkg::TARGET_W-1:0]       target,
    input  logic signed [mtvb_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [mtvb_pkg::POS_W-1:0]   pos_x,
    input  logic signed [mtvb_pkg::POS_W-1:0]   pos_y,
    input  logic signed [mtvb_pkg::POS_W-1:0]   pos_z,
    // results
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mtvb_pkg::SLOT_W-1:0]         out_slot,
    output logic signed [mtvb_pkg::POS_W-1:0]   out_x,
    output logic signed [mtvb_pkg::POS_W-1:0]   out_y,
    output logic signed [mtvb_pkg::POS_W-1:0]   out_z
);
    import mtvb_pkg::*;

    localparam int ADDR_W = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int TGT_IW = $clog2(MAX_TARGETS);

    // configuration registers
    logic              blend_mode_reg;
    logic [FRAC_W-1:0] frame_fraction_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg     <= 1'b0;
            frame_fraction_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_BLEND_MODE:     blend_mode_reg     <= cfg_data[0];
                REG_FRAME_FRACTION: frame_fraction_reg <= cfg_data;
                default:            blend_mode_reg     <= blend_mode_reg;
            endcase
        end
    end

    // weight table and running total
    logic signed [WEIGHT_W-1:0] weight_reg [MAX_TARGETS];
    logic signed [TOTAL_W-1:0]  total_reg;

    state_t state_reg, state_next;
    logic   in_accept;
    logic   tgt_ok;
    logic   slot_ok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign tgt_ok    = ({{(32-TARGET_W){1'b0}}, target} < 32'(MAX_TARGETS));
    assign slot_ok   = ({{(32-SLOT_W){1'b0}}, slot} < 32'(VERTEX_SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_TARGETS; i++)
                weight_reg[i] <= '0;
            total_reg <= '0;
        end
        else if (in_accept && func_t'(func) == FUNC_WEIGHT && tgt_ok)
        begin
            weight_reg[target[TGT_IW-1:0]] <= weight;
            total_reg <= total_reg - TOTAL_W'(weight_reg[target[TGT_IW-1:0]])
                         + TOTAL_W'(weight);
        end
    end

    // item registers
    logic [ADDR_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   oslot_reg;
    logic [3*POS_W-1:0]  vpos_reg;
    logic [T_W-1:0]      t_reg, t_next;
    logic signed [WEIGHT_W-1:0] w_cur;

    assign w_cur = tgt_ok ? weight_reg[target[TGT_IW-1:0]] : '0;

    // divider
    logic           div_start;
    logic           div_done;
    logic [T_W-1:0] div_q;

    mtvb_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend_w (w_cur[WEIGHT_W-2:0]),
        .divisor    (total_reg),
        .done       (div_done),
        .quotient   (div_q)
    );

    // position store
    logic               st_rd_en;
    logic [3*POS_W-1:0] st_rd_data;
    logic               st_wr_en;
    logic [3*POS_W-1:0] st_wr_data;

    mtvb_store #(
        .VERTEX_SLOTS (VERTEX_SLOTS),
        .ADDR_W       (ADDR_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (st_rd_en),
        .rd_addr (slot_reg),
        .rd_data (st_rd_data),
        .wr_en   (st_wr_en),
        .wr_addr (in_accept ? slot[ADDR_W-1:0] : slot_reg),
        .wr_data (st_wr_data)
    );

    // multiply stage: per coordinate acc + trunc((v - acc) * t / 2^16)
    logic signed [49:0] prod_reg [3];
    logic signed [POS_W-1:0] acc_reg [3];
    logic [3*POS_W-1:0] res_w;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            for (int k = 0; k < 3; k++)
            begin
                acc_reg[k]  <= st_rd_data[k*POS_W +: POS_W];
                prod_reg[k] <= (50'(signed'(vpos_reg[k*POS_W +: POS_W]))
                                - 50'(signed'(st_rd_data[k*POS_W +: POS_W])))
                               * signed'({33'd0, t_reg});
            end
        end
    end

    always_comb
    begin
        logic signed [49:0] q;
        for (int k = 0; k < 3; k++)
        begin
            q = (prod_reg[k] < 0) ? -((-prod_reg[k]) >>> 16) : (prod_reg[k] >>> 16);
            res_w[k*POS_W +: POS_W] = sat32(50'(acc_reg[k]) + q);
        end
    end

    // output register
    logic               out_valid_reg;
    logic [3*POS_W-1:0] out_pos_reg;
    logic [3*POS_W-1:0] res_hold_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    // control
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        st_rd_en   = 1'b0;
        st_wr_en   = 1'b0;
        st_wr_data = res_w;
        t_next     = t_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && slot_ok && func_t'(func) == FUNC_BASE)
                begin
                    st_wr_en   = 1'b1;
                    st_wr_data = {pos_z, pos_y, pos_x};
                end
                else if (in_accept && slot_ok && func_t'(func) == FUNC_BLEND)
                begin
                    if (blend_mode_reg)
                    begin
                        t_next     = {1'b0, frame_fraction_reg};
                        state_next = ST_READ;
                    end
                    else if (w_cur < 0)
                    begin
                        t_next     = '0;
                        state_next = ST_READ;
                    end
                    else if (total_reg > ONE_Q14)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        t_next     = {w_cur[WEIGHT_W-2:0], 2'b00};
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    t_next     = div_q;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                st_rd_en   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_WRITE;
            ST_WRITE:
            begin
                st_wr_en   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        if (in_accept)
        begin
            slot_reg  <= slot[ADDR_W-1:0];
            oslot_reg <= slot;
            vpos_reg  <= {pos_z, pos_y, pos_x};
        end
        if (state_reg == ST_WRITE)
            res_hold_reg <= res_w;
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            out_pos_reg  <= res_hold_reg;
            out_slot_reg <= oslot_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_x     = out_pos_reg[0*POS_W +: POS_W];
    assign out_y     = out_pos_reg[1*POS_W +: POS_W];
    assign out_z     = out_pos_reg[2*POS_W +: POS_W];

    // checks
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_wb_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> st_wr_en)
        else $error("write-back missing after multiply");
    a_rd_before_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> $past(st_rd_en))
        else $error("multiply without store read");

endmodule
